// File: rtl/core/gaussian_kernel_quadrant_writer_assert.svh
// Assertion macros for the Gaussian kernel quadrant writer.
// Included by the top level; depends on nothing else.
`ifndef GAUSSIAN_KERNEL_QUADRANT_WRITER_ASSERT_SVH
`define GAUSSIAN_KERNEL_QUADRANT_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GKQW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gkqw: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define GKQW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gkqw: next-cycle check failed");

`endif

// File: rtl/core/gkqw_pkg.sv
// Package for the Gaussian kernel quadrant writer: field widths, register
// indexes, mirror codes and the 2^-f table entry function. No dependencies.
`timescale 1ns / 1ps

package gkqw_pkg;

	// Field widths
	localparam int COORD_W  = 12;
	localparam int SIDE_W   = 13;
	localparam int PCOUNT_W = 3;
	localparam int INV_W    = 32;
	localparam int PLANE_W  = 2;
	localparam int OFFSET_W = 24;
	localparam int VALUE_W  = 17;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IMAGE_WIDTH   = 3'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT  = 3'd1;
	localparam cfg_idx_t CFG_LINE_STRIDE   = 3'd2;
	localparam cfg_idx_t CFG_PLANE_COUNT   = 3'd3;
	localparam cfg_idx_t CFG_INV_RADIUS_SQ = 3'd4;

	// Register reset values
	localparam logic [SIDE_W-1:0]   RST_IMAGE_WIDTH   = 13'd64;
	localparam logic [SIDE_W-1:0]   RST_IMAGE_HEIGHT  = 13'd64;
	localparam logic [SIDE_W-1:0]   RST_LINE_STRIDE   = 13'd64;
	localparam logic [PCOUNT_W-1:0] RST_PLANE_COUNT   = 3'd1;
	localparam logic [INV_W-1:0]    RST_INV_RADIUS_SQ = 32'd16777216;

	// Planes written at most; larger counts are clamped to this
	localparam int MAX_PLANES = 4;

	// Exponent arithmetic: d2 is col^2 + row^2, exponent is d2 * Q8.24
	localparam int FRAC_BITS   = 24;
	localparam int D2_W        = 25;
	localparam int EXP_W       = D2_W + INV_W;
	localparam int SHIFT_W     = 5;
	localparam int SHIFT_LIMIT = 17;

	// Order of the writes of one plane
	typedef logic [1:0] mirror_t;
	localparam mirror_t MIR_DIR = 2'd0;
	localparam mirror_t MIR_COL = 2'd1;
	localparam mirror_t MIR_ROW = 2'd2;
	localparam mirror_t MIR_DBL = 2'd3;

	localparam logic [63:0] LN2_Q48 = 64'hB17217F7D1CF;

	// One table entry: 2^(-idx / 2^tbits) in Q0.16, rounded to nearest.
	// Evaluated at elaboration only; exp(-x) by a 24-term series in Q32.
	function automatic logic [VALUE_W-1:0] pow_entry(input int unsigned idx,
							 input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		int unsigned k;
		x    = (((64'(idx) * LN2_Q48) >> tbits) + 64'd32768) >> 16;
		term = 64'd1 << 32;
		sum  = term;
		for (k = 1; k <= 24; k++) begin
			term = ((term * x) >> 32) / 64'(k);
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		v = (sum + 64'd32768) >> 16;
		return v[VALUE_W-1:0];
	endfunction

endpackage

// File: rtl/core/gaussian_kernel_quadrant_writer.sv
// Gaussian kernel quadrant writer: turns quarter-plane positions into mirrored
// buffer writes of a circularly wrapped Gaussian. Depends on gkqw_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "gaussian_kernel_quadrant_writer_assert.svh"

// Each input word carries one quarter-plane position (col, row). The block
// computes value = 2^-(d2 * inv_radius_sq), d2 = col^2 + row^2, in unsigned
// Q0.16 (65536 is one) and emits it as buffer writes: for every plane in turn
// the direct cell, then the column mirror if col is nonzero, the row mirror if
// row is nonzero, and the double mirror if both are. The final write of a
// position carries tlast. Offsets are column + line_stride * row, modulo 2^24.
// Positions beyond image_width/2 or image_height/2, or a plane count of zero,
// give no writes and are dropped at the input. The value path is a five-stage
// pipeline (squares and bounds, d2 and row products, exponent multiply and
// offsets, table lookup and shift, output register); a position passes
// through the stages in that order before its first write appears. A new
// position may enter every cycle unless the input is stalled; the output
// register emits one write per cycle while the receiver is ready, so a
// position gives between the clamped plane count and four times that count
// writes (at most 16), which sets the sustained rate. A dropped position is
// taken at the input and gives no write. The input keeps taking words while
// the output drains, until all four pipeline stages hold a position.
// Write configuration registers only while no position is in flight.
module gaussian_kernel_quadrant_writer #(
	parameter int TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Configuration write port
	input  logic                            cfg_we,
	input  logic [gkqw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gkqw_pkg::CFG_DATA_W-1:0] cfg_data,

	// Position stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [gkqw_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // col[11:0], row[23:12]

	// Write stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [gkqw_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // plane[1:0], offset[25:2],
	                                                        // value[42:26], zero[47:43]
	output logic                            m_axis_tlast
);

	import gkqw_pkg::*;

	localparam int TABLE_SIZE = 1 << TABLE_BITS;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [SIDE_W-1:0]   image_width_q;
	logic [SIDE_W-1:0]   image_height_q;
	logic [SIDE_W-1:0]   line_stride_q;
	logic [PCOUNT_W-1:0] plane_count_q;
	logic [INV_W-1:0]    inv_radius_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= RST_IMAGE_WIDTH;
			image_height_q  <= RST_IMAGE_HEIGHT;
			line_stride_q   <= RST_LINE_STRIDE;
			plane_count_q   <= RST_PLANE_COUNT;
			inv_radius_sq_q <= RST_INV_RADIUS_SQ;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data[SIDE_W-1:0];
				CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[SIDE_W-1:0];
				CFG_LINE_STRIDE:   line_stride_q   <= cfg_data[SIDE_W-1:0];
				CFG_PLANE_COUNT:   plane_count_q   <= cfg_data[PCOUNT_W-1:0];
				CFG_INV_RADIUS_SQ: inv_radius_sq_q <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Planes actually written: clamp to MAX_PLANES
	logic [PCOUNT_W-1:0] num_planes;
	logic [PCOUNT_W-1:0] last_plane;

	assign num_planes = (plane_count_q > PCOUNT_W'(MAX_PLANES)) ?
		PCOUNT_W'(MAX_PLANES) : plane_count_q;
	assign last_plane = num_planes - PCOUNT_W'(1);

	// ---------------------------------------------------------------------
	// Constant table of 2^-f in Q0.16, filled at elaboration
	// ---------------------------------------------------------------------
	logic [VALUE_W-1:0] pow_rom [TABLE_SIZE];

	for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
		localparam logic [VALUE_W-1:0] ENTRY = pow_entry(gi, TABLE_BITS);
		assign pow_rom[gi] = ENTRY;
	end

	// ---------------------------------------------------------------------
	// Stall chain: a stage takes new data when empty or when it hands on
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic emit_load;
	logic out_valid_q;
	logic out_last;

	// The output register frees up when it is empty or its final write goes.
	assign emit_load = v_s4 && (!out_valid_q || (m_axis_tready && out_last));
	assign en_s4 = !v_s4 || emit_load;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// ---------------------------------------------------------------------
	// Stage 1: squares, mirror distances, bounds check
	// ---------------------------------------------------------------------
	logic [COORD_W-1:0] in_col;
	logic [COORD_W-1:0] in_row;
	logic               in_keep;

	assign in_col  = s_axis_tdata[COORD_W-1:0];
	assign in_row  = s_axis_tdata[2*COORD_W-1:COORD_W];
	// Drop positions past half the image, and everything when no plane is on.
	assign in_keep = (in_col <= image_width_q[SIDE_W-1:1]) &&
			 (in_row <= image_height_q[SIDE_W-1:1]) &&
			 (num_planes != '0);

	logic [COORD_W-1:0]   col_s1;
	logic [COORD_W-1:0]   row_s1;
	logic [2*COORD_W-1:0] sqc_s1;
	logic [2*COORD_W-1:0] sqr_s1;
	logic [SIDE_W-1:0]    cmir_s1;
	logic [SIDE_W-1:0]    hmr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= s_axis_tvalid && in_keep;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			col_s1  <= in_col;
			row_s1  <= in_row;
			sqc_s1  <= (2*COORD_W)'(in_col) * (2*COORD_W)'(in_col);
			sqr_s1  <= (2*COORD_W)'(in_row) * (2*COORD_W)'(in_row);
			cmir_s1 <= image_width_q - {1'b0, in_col};
			hmr_s1  <= image_height_q - {1'b0, in_row};
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: d2 and the two row products
	// ---------------------------------------------------------------------
	localparam int RDIR_W = SIDE_W + COORD_W;
	localparam int RMIR_W = 2 * SIDE_W;

	logic [COORD_W-1:0] col_s2;
	logic [SIDE_W-1:0]  cmir_s2;
	logic               colnz_s2;
	logic               rownz_s2;
	logic [D2_W-1:0]    d2_s2;
	logic [RDIR_W-1:0]  rdir_s2;
	logic [RMIR_W-1:0]  rmir_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			col_s2   <= col_s1;
			cmir_s2  <= cmir_s1;
			colnz_s2 <= (col_s1 != '0);
			rownz_s2 <= (row_s1 != '0);
			d2_s2    <= D2_W'(sqc_s1) + D2_W'(sqr_s1);
			rdir_s2  <= RDIR_W'(line_stride_q) * RDIR_W'(row_s1);
			rmir_s2  <= RMIR_W'(line_stride_q) * RMIR_W'(hmr_s1);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: exponent product, the four offsets
	// ---------------------------------------------------------------------
	logic [OFFSET_W-1:0] col_ext;
	logic [OFFSET_W-1:0] cmir_ext;

	assign col_ext  = {{(OFFSET_W-COORD_W){1'b0}}, col_s2};
	assign cmir_ext = {{(OFFSET_W-SIDE_W){1'b0}}, cmir_s2};

	logic [EXP_W-1:0]    exp_s3;
	logic [OFFSET_W-1:0] off_dir_s3;
	logic [OFFSET_W-1:0] off_col_s3;
	logic [OFFSET_W-1:0] off_row_s3;
	logic [OFFSET_W-1:0] off_dbl_s3;
	logic                colnz_s3;
	logic                rownz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en_s3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			exp_s3     <= EXP_W'(d2_s2) * EXP_W'(inv_radius_sq_q);
			off_dir_s3 <= col_ext + rdir_s2[OFFSET_W-1:0];
			off_col_s3 <= cmir_ext + rdir_s2[OFFSET_W-1:0];
			off_row_s3 <= col_ext + rmir_s2[OFFSET_W-1:0];
			off_dbl_s3 <= cmir_ext + rmir_s2[OFFSET_W-1:0];
			colnz_s3   <= colnz_s2;
			rownz_s3   <= rownz_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: table lookup on the fraction, shift by the integer part
	// ---------------------------------------------------------------------
	logic [TABLE_BITS-1:0] tab_idx;
	logic [SHIFT_W-1:0]    exp_int;
	logic                  exp_big;

	assign tab_idx = exp_s3[FRAC_BITS-1 -: TABLE_BITS];
	assign exp_int = exp_s3[FRAC_BITS+SHIFT_W-1:FRAC_BITS];
	// Integer part of 17 or more shifts everything out.
	assign exp_big = (|exp_s3[EXP_W-1:FRAC_BITS+SHIFT_W]) ||
			 (exp_int >= SHIFT_W'(SHIFT_LIMIT));

	logic [VALUE_W-1:0]  value_s4;
	logic [OFFSET_W-1:0] off_dir_s4;
	logic [OFFSET_W-1:0] off_col_s4;
	logic [OFFSET_W-1:0] off_row_s4;
	logic [OFFSET_W-1:0] off_dbl_s4;
	logic                colnz_s4;
	logic                rownz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_s4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			value_s4   <= exp_big ? '0 : (pow_rom[tab_idx] >> exp_int);
			off_dir_s4 <= off_dir_s3;
			off_col_s4 <= off_col_s3;
			off_row_s4 <= off_row_s3;
			off_dbl_s4 <= off_dbl_s3;
			colnz_s4   <= colnz_s3;
			rownz_s4   <= rownz_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: walk planes and mirrors; while ready is high, one write per cycle
	// ---------------------------------------------------------------------
	logic [PCOUNT_W-1:0] plane_q;
	mirror_t             mir_q;
	logic                colnz_q;
	logic                rownz_q;
	logic [VALUE_W-1:0]  value_q;
	logic [OFFSET_W-1:0] off_dir_q;
	logic [OFFSET_W-1:0] off_col_q;
	logic [OFFSET_W-1:0] off_row_q;
	logic [OFFSET_W-1:0] off_dbl_q;

	mirror_t             mir_next;
	logic                mir_more;
	logic [OFFSET_W-1:0] off_sel;

	// Next enabled mirror of the same plane, if any
	always_comb begin
		mir_next = MIR_DIR;
		mir_more = 1'b0;
		case (mir_q)
			MIR_DIR: begin
				if (colnz_q) begin
					mir_next = MIR_COL;
					mir_more = 1'b1;
				end else if (rownz_q) begin
					mir_next = MIR_ROW;
					mir_more = 1'b1;
				end
			end
			MIR_COL: begin
				if (rownz_q) begin
					mir_next = MIR_ROW;
					mir_more = 1'b1;
				end
			end
			MIR_ROW: begin
				if (colnz_q) begin
					mir_next = MIR_DBL;
					mir_more = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (mir_q)
			MIR_DIR: off_sel = off_dir_q;
			MIR_COL: off_sel = off_col_q;
			MIR_ROW: off_sel = off_row_q;
			MIR_DBL: off_sel = off_dbl_q;
			default: off_sel = off_dir_q;
		endcase
	end

	assign out_last = (plane_q == last_plane) && !mir_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			plane_q     <= '0;
			mir_q       <= MIR_DIR;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
			plane_q     <= '0;
			mir_q       <= MIR_DIR;
		end else if (out_valid_q && m_axis_tready) begin
			if (out_last) begin
				out_valid_q <= 1'b0;
			end else if (mir_more) begin
				mir_q <= mir_next;
			end else begin
				plane_q <= plane_q + PCOUNT_W'(1);
				mir_q   <= MIR_DIR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			colnz_q   <= colnz_s4;
			rownz_q   <= rownz_s4;
			value_q   <= value_s4;
			off_dir_q <= off_dir_s4;
			off_col_q <= off_col_s4;
			off_row_q <= off_row_s4;
			off_dbl_q <= off_dbl_s4;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last;
	assign m_axis_tdata  = {{(OUT_DATA_W-VALUE_W-OFFSET_W-PLANE_W){1'b0}},
				value_q, off_sel, plane_q[PLANE_W-1:0]};

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	// The plane walk never runs past the clamped plane count.
	`GKQW_ASSERT_NOW(a_plane_in_range, clk, arst_n, out_valid_q, plane_q < num_planes)
	// A write that is not the last of its position is always followed by another.
	`GKQW_ASSERT_NEXT(a_no_gap_in_run, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
	// The double mirror is only ever reached when both coordinates are nonzero.
	`GKQW_ASSERT_NOW(a_dbl_mirror_ok, clk, arst_n,
		out_valid_q && (mir_q == MIR_DBL), colnz_q && rownz_q)
	// Input back-pressure only when every pipeline stage is occupied.
	`GKQW_ASSERT_NOW(a_stall_full, clk, arst_n, !s_axis_tready,
		v_s1 && v_s2 && v_s3 && v_s4)

endmodule

// File: test/gaussian_kernel_quadrant_writer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gaussian_kernel_quadrant_writer: streams quarter-plane positions,
// predicts every mirrored Gaussian write and checks each output word. Depends on gkqw_pkg.

module gaussian_kernel_quadrant_writer_tb;
	import gkqw_pkg::*;

	localparam int LUT_BITS     = 10;    // table size of the block under test (default)
	localparam int DRAIN_CYCLES = 16;    // five-stage pipeline plus margin
	localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
	localparam int SQUEEZE_AT   = 600;   // output words seen before the long hold-off
	localparam int SQUEEZE_LEN  = 600;   // length of the long hold-off in cycles

	// One expected buffer write
	typedef struct {
		logic [PLANE_W-1:0]  plane;
		logic [OFFSET_W-1:0] offset;
		logic [VALUE_W-1:0]  value;
		logic                last;
	} write_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	cfg_idx_t              cfg_index     = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // col[11:0], row[23:12]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // plane[1:0], offset[25:2], value[42:26]
	logic                  m_axis_tlast;

	// Register copies seen by the predictor; change only while the block is idle
	logic [SIDE_W-1:0]   cur_width  = RST_IMAGE_WIDTH;
	logic [SIDE_W-1:0]   cur_height = RST_IMAGE_HEIGHT;
	logic [SIDE_W-1:0]   cur_stride = RST_LINE_STRIDE;
	logic [PCOUNT_W-1:0] cur_planes = RST_PLANE_COUNT;
	logic [INV_W-1:0]    cur_inv    = RST_INV_RADIUS_SQ;

	logic [VALUE_W-1:0] half_pow [1 << LUT_BITS];  // 2^(-i/1024) in Q0.16
	logic [IN_DATA_W-1:0] position_q [$];          // positions waiting for the driver
	write_t writes_due [$];                        // writes predicted, not yet seen
	int errors = 0;

	// Driver and receiver bookkeeping
	int burst_left = 0;
	int gap_left   = 0;
	int ready_left = 0;
	int stall_left = 0;
	int hold_left  = 0;
	bit squeezed   = 1'b0;
	int words_out  = 0;
	int quiet_cycles = 0;

	gaussian_kernel_quadrant_writer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Table entry: exp(-i*ln2/1024) by a 24-term series in Q32, rounded to Q0.16
	function automatic logic [VALUE_W-1:0] half_pow_entry(input int unsigned i);
		logic [63:0] arg;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] rounded;
		int unsigned k;
		arg  = (((64'(i) * LN2_Q48) >> LUT_BITS) + 64'd32768) >> 16;
		term = 64'd1 << 32;
		acc  = term;
		for (k = 1; k <= 24; k++) begin
			term = ((term * arg) >> 32) / 64'(k);
			acc  = k[0] ? acc - term : acc + term;
		end
		rounded = (acc + 64'd32768) >> 16;
		return rounded[VALUE_W-1:0];
	endfunction

	function automatic logic [IN_DATA_W-1:0] pos(input int unsigned col, input int unsigned row);
		return {row[COORD_W-1:0], col[COORD_W-1:0]};
	endfunction

	// Expected writes of one accepted position, under the current register copies
	task automatic predict_writes(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
		logic [63:0] d2;
		logic [63:0] expo;
		logic [63:0] rdir;
		logic [63:0] rmir;
		logic [63:0] cmir;
		logic [VALUE_W-1:0] val;
		int unsigned np;
		int unsigned p;
		int m;
		mirror_t mir;
		write_t w;
		// drop positions past the half image, and a zero plane count
		if (col > cur_width / 2 || row > cur_height / 2)
			return;
		np = (cur_planes > MAX_PLANES) ? MAX_PLANES : cur_planes;
		if (np == 0)
			return;
		d2   = 64'(col) * 64'(col) + 64'(row) * 64'(row);
		expo = d2 * 64'(cur_inv);
		if ((expo >> FRAC_BITS) >= SHIFT_LIMIT)
			val = '0;
		else
			val = half_pow[expo[FRAC_BITS-1 -: LUT_BITS]] >> (expo >> FRAC_BITS);
		rdir = 64'(cur_stride) * 64'(row);
		rmir = 64'(cur_stride) * (64'(cur_height) - 64'(row));
		cmir = 64'(cur_width) - 64'(col);
		for (p = 0; p < np; p++) begin
			// bit 0 of the mirror code flips the column, bit 1 the row
			for (m = 0; m < 4; m++) begin
				mir = mirror_t'(m);
				if (mir[0] && col == 0)
					continue;
				if (mir[1] && row == 0)
					continue;
				w.plane  = PLANE_W'(p);
				w.offset = OFFSET_W'((mir[0] ? cmir : 64'(col)) + (mir[1] ? rmir : rdir));
				w.value  = val;
				w.last   = 1'b0;
				writes_due.push_back(w);
			end
		end
		writes_due[$].last = 1'b1;
	endtask

	// Mostly in-bounds positions with random content, plus edges, just-outside and noise
	function automatic logic [IN_DATA_W-1:0] random_position();
		int unsigned hw;
		int unsigned hh;
		int unsigned col;
		int unsigned row;
		int unsigned pick;
		hw   = cur_width / 2;
		hh   = cur_height / 2;
		pick = $urandom_range(0, 99);
		col  = $urandom_range(0, hw);
		row  = $urandom_range(0, hh);
		if (pick < 8)
			return IN_DATA_W'($urandom);
		if (pick < 14) begin
			if ($urandom_range(0, 1))
				col = (hw < 4095) ? hw + 1 : hw;
			else
				row = (hh < 4095) ? hh + 1 : hh;
		end else if (pick < 26) begin
			col = $urandom_range(0, 1) ? hw : 0;
			row = $urandom_range(0, 1) ? hh : 0;
		end
		return pos(col, row);
	endfunction

	// Wait until no position is queued or offered and every write has come, then drain
	task automatic settle();
		do
			@(negedge clk);
		while (position_q.size() != 0 || s_axis_tvalid || writes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all five registers on consecutive cycles while idle
	task automatic load_config(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
				   input logic [SIDE_W-1:0] s, input logic [PCOUNT_W-1:0] p,
				   input logic [INV_W-1:0] inv);
		settle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= CFG_LINE_STRIDE;
		cfg_data  <= CFG_DATA_W'(s);
		@(posedge clk);
		cfg_index <= CFG_PLANE_COUNT;
		cfg_data  <= CFG_DATA_W'(p);
		@(posedge clk);
		cfg_index <= CFG_INV_RADIUS_SQ;
		cfg_data  <= CFG_DATA_W'(inv);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_width  = w;
		cur_height = h;
		cur_stride = s;
		cur_planes = p;
		cur_inv    = inv;
	endtask

	// Driver: offer positions in bursts of random length, with random gaps between them.
	// Predict the writes of a position at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_writes(s_axis_tdata[COORD_W-1:0], s_axis_tdata[2*COORD_W-1:COORD_W]);
			// hold the word while it is offered and not taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (position_q.size() != 0) begin
					// long bursts give stretches with no gaps at all
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(40, 120) : $urandom_range(1, 16);
					s_axis_tdata  <= position_q.pop_front();
					s_axis_tvalid <= 1'b1;
					burst_left--;
					if (burst_left == 0)
						gap_left = $urandom_range(1, 10);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready runs and short stalls of random length; once, a long hold-off
	// while the sender keeps offering, so the pipeline fills and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				words_out++;
			if (!squeezed && words_out >= SQUEEZE_AT) begin
				squeezed  = 1'b1;
				hold_left = SQUEEZE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (ready_left == 0)
					ready_left = ($urandom_range(0, 3) == 0) ?
						$urandom_range(50, 200) : $urandom_range(1, 12);
				m_axis_tready <= 1'b1;
				ready_left--;
				if (ready_left == 0)
					stall_left = $urandom_range(1, 6);
			end
		end
	end

	// Monitor: compare each accepted write word with the oldest prediction
	always @(posedge clk) begin
		write_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (writes_due.size() == 0) begin
				$display("%0t: write word with none expected: tdata=%h tlast=%0b",
					 $time, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				due = writes_due.pop_front();
				if (m_axis_tdata[PLANE_W-1:0] !== due.plane) begin
					$display("%0t: plane expected %0d actual %0d", $time,
						 due.plane, m_axis_tdata[PLANE_W-1:0]);
					errors++;
				end
				if (m_axis_tdata[PLANE_W +: OFFSET_W] !== due.offset) begin
					$display("%0t: offset expected %0d actual %0d", $time,
						 due.offset, m_axis_tdata[PLANE_W +: OFFSET_W]);
					errors++;
				end
				if (m_axis_tdata[PLANE_W+OFFSET_W +: VALUE_W] !== due.value) begin
					$display("%0t: value expected %0d actual %0d", $time,
						 due.value, m_axis_tdata[PLANE_W+OFFSET_W +: VALUE_W]);
					errors++;
				end
				if (m_axis_tlast !== due.last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						 due.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, %0d writes still expected", $time, writes_due.size());
				$display("** gaussian_kernel_quadrant_writer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int unsigned i;
		int ph;
		int k;
		int n_items;
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		logic [SIDE_W-1:0] s;
		logic [PCOUNT_W-1:0] np;
		logic [63:0] inv;
		for (i = 0; i < (1 << LUT_BITS); i++)
			half_pow[i] = half_pow_entry(i);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: radius one, so the value halves per unit of d2.
		// Cover the origin, single axes, both edges and just past them.
		position_q.push_back(pos(0, 0));
		position_q.push_back(pos(1, 0));
		position_q.push_back(pos(0, 1));
		position_q.push_back(pos(1, 1));
		position_q.push_back(pos(2, 3));
		position_q.push_back(pos(32, 0));
		position_q.push_back(pos(0, 32));
		position_q.push_back(pos(32, 32));
		position_q.push_back(pos(33, 0));
		position_q.push_back(pos(0, 33));
		position_q.push_back(pos(33, 33));
		position_q.push_back(pos(4095, 4095));

		// Largest nominal image, four planes, wide radius
		load_config(13'd4096, 13'd4096, 13'd4096, 3'd4, 32'h10);
		position_q.push_back(pos(2048, 2048));
		position_q.push_back(pos(2048, 0));
		position_q.push_back(pos(0, 2048));
		position_q.push_back(pos(2049, 0));
		position_q.push_back(pos(0, 2049));
		position_q.push_back(pos(1024, 2047));

		// Widest registers: full coordinate range, offsets wrap, plane count clamped
		load_config(13'd8191, 13'd8191, 13'd8191, 3'd7, 32'd9);
		position_q.push_back(pos(4095, 4095));
		position_q.push_back(pos(4095, 0));
		position_q.push_back(pos(0, 4095));
		for (k = 0; k < 20; k++)
			position_q.push_back(random_position());

		// Zero width and height: only the origin is valid; steepest radius
		load_config(13'd0, 13'd0, 13'd1, 3'd4, 32'hFFFF_FFFF);
		position_q.push_back(pos(0, 0));
		position_q.push_back(pos(1, 0));
		position_q.push_back(pos(0, 1));
		for (k = 0; k < 15; k++)
			position_q.push_back(random_position());

		// No planes: every position is dropped
		load_config(13'd64, 13'd64, 13'd64, 3'd0, 32'h0100_0000);
		for (k = 0; k < 10; k++)
			position_q.push_back(random_position());

		// One-cell image, flat kernel, plane count just past the maximum
		load_config(13'd1, 13'd1, 13'd1, 3'd5, 32'd0);
		for (k = 0; k < 15; k++)
			position_q.push_back(random_position());

		// Tiny even and odd sides: on the even side the mirror lands on the same cell
		load_config(13'd2, 13'd3, 13'd5, 3'd2, 32'h0100_0000);
		for (k = 0; k < 20; k++)
			position_q.push_back(random_position());

		// Random settings; radius mostly scaled to the image so values spread out
		for (ph = 0; ph < 8; ph++) begin
			w  = SIDE_W'($urandom_range(0, 1) ? $urandom_range(1, 80) :
				$urandom_range(1, 8191));
			h  = SIDE_W'($urandom_range(0, 1) ? $urandom_range(1, 80) :
				$urandom_range(1, 8191));
			s  = SIDE_W'($urandom_range(1, 8191));
			np = PCOUNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) :
				$urandom_range(1, 4));
			if ($urandom_range(0, 5) == 0)
				inv = 64'($urandom);
			else
				inv = ((64'd17 << 24) / (64'(w / 2) * 64'(w / 2) + 64'(h / 2) * 64'(h / 2)
					+ 64'd1)) * 64'($urandom_range(1, 8)) / 64'd4;
			load_config(w, h, s, np, INV_W'(inv));
			n_items = (np == 0) ? 10 : 50;
			for (k = 0; k < n_items; k++)
				position_q.push_back(random_position());
		end

		settle();
		if (errors == 0)
			$display("** gaussian_kernel_quadrant_writer: PASSED **");
		else
			$display("** gaussian_kernel_quadrant_writer: FAILED **");
		$finish;
	end

endmodule

// File: gaussian_kernel_quadrant_writer.f
+incdir+rtl/core
rtl/core/gkqw_pkg.sv
rtl/core/gaussian_kernel_quadrant_writer.sv
test/gaussian_kernel_quadrant_writer_tb.sv
